FILE: rtl/rpvg_pkg.sv
// Shared types, constants and the arctangent table for the rectangle vertex generator.
`timescale 1ns / 1ps
package rpvg_pkg;

    localparam int COORD_WIDTH_DEF  = 32;
    localparam int CORDIC_STEPS_DEF = 16;

    // CORDIC datapath widths: x/y in Q30, z in Q16 degrees
    localparam int CW = 32;
    localparam int ZW = 26;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032875;

    // angles in Q24.8 degrees
    localparam logic [16:0] DEG90  = 17'd23040;
    localparam logic [16:0] DEG180 = 17'd46080;
    localparam logic [16:0] DEG270 = 17'd69120;
    localparam logic [16:0] DEG360 = 17'd92160;

    // ceil(2^32 / 45), used to divide by 360 degrees after a shift by 11
    localparam logic signed [27:0] RECIP45 = 28'sd95443718;

    localparam logic [2:0] KIND_SOLID  = 3'd0;
    localparam logic [2:0] KIND_HAZARD = 3'd1;

    localparam logic [1:0] SUPPORT_NONE = 2'd1;

    localparam logic [2:0] SHAPE_TRIANGLE = 3'd0;
    localparam logic [2:0] SHAPE_AXIS     = 3'd1;
    localparam logic [2:0] SHAPE_ROTATED  = 3'd2;
    localparam logic [2:0] SHAPE_HAZARD   = 3'd3;
    localparam logic [2:0] SHAPE_REF      = 3'd4;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
        logic signed [ZW-1:0] r;
        case (i)
            0:  r = 26'sd2949120;
            1:  r = 26'sd1740967;
            2:  r = 26'sd919879;
            3:  r = 26'sd466945;
            4:  r = 26'sd234379;
            5:  r = 26'sd117305;
            6:  r = 26'sd58666;
            7:  r = 26'sd29335;
            8:  r = 26'sd14668;
            9:  r = 26'sd7334;
            10: r = 26'sd3667;
            11: r = 26'sd1833;
            12: r = 26'sd917;
            13: r = 26'sd458;
            14: r = 26'sd229;
            15: r = 26'sd115;
            16: r = 26'sd57;
            17: r = 26'sd29;
            18: r = 26'sd14;
            19: r = 26'sd7;
            20: r = 26'sd4;
            21: r = 26'sd2;
            22: r = 26'sd1;
            default: r = 26'sd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/rpvg_cordic_cell.sv
// One rotation-mode CORDIC step with its output register.
`timescale 1ns / 1ps
module rpvg_cordic_cell
    import rpvg_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic    clk,
    input  logic    en,
    input  cordic_t din,
    output cordic_t dout
);

    cordic_t dout_reg;
    cordic_t dout_next;

    always_comb
    begin
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xs = din.x >>> STEP;
        ys = din.y >>> STEP;
        if (din.z >= 0)
        begin
            dout_next.x = din.x - ys;
            dout_next.y = din.y + xs;
            dout_next.z = din.z - atan_q16(STEP);
        end
        else
        begin
            dout_next.x = din.x + ys;
            dout_next.y = din.y - xs;
            dout_next.z = din.z + atan_q16(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

FILE: rtl/rect_primitive_vertex_generator.sv
// Top level: angle reduction, CORDIC cell chain, corner rotation and vertex output.
`timescale 1ns / 1ps
// Takes one object per transaction and returns its corners one per transaction: four for a
// rectangle, three for a slope triangle, with tlast on the final one. An object enters
// whenever the pipeline can move, so new objects are taken while earlier ones are still
// being sent, and the output channel sets the sustained rate. On its way to the first
// vertex an object passes the angle reduction and classification stages, the CORDIC
// cells, then offset, two multiply and vertex stages, then the output register. A stall
// on the output holds the whole pipeline once stage 7 holds an object.
module rect_primitive_vertex_generator
    import rpvg_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,

    input  logic s_tvalid,
    output logic s_tready,
    // rect_x, rect_y, rect_width, rect_height, rotation_degrees, zero pad
    input  logic [((4*COORD_WIDTH+32+7)/8)*8-1:0] s_tdata,
    // object_kind, is_slope, support_class
    input  logic [5:0] s_tuser,

    output logic m_tvalid,
    input  logic m_tready,
    // vertex_x, vertex_y, vertex_number, zero pad
    output logic [((2*COORD_WIDTH+2+7)/8)*8-1:0] m_tdata,
    // shape_class, verification
    output logic [3:0] m_tuser,
    output logic       m_tlast
);

    localparam int W      = COORD_WIDTH;
    localparam int N      = CORDIC_STEPS;
    localparam int OW     = W + 1;
    localparam int PW     = OW + 32;
    localparam int SW     = PW + 2;
    localparam int OUT_W  = ((2*W+2+7)/8)*8;
    localparam int SIDE_W = 4*W + 7;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [SW-1:0] ROUND  = SW'(1) <<< 29;

    logic       adv;
    logic       load;
    logic [7:0] tol_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= 8'd3;
        end
        else if (cfg_wr_en)
        begin
            tol_reg <= cfg_wr_data;
        end
    end

    assign s_tready = adv;

    // ---------------- stage 1: capture, start divide by 360 degrees
    logic                      s1_valid_reg;
    logic signed [W-1:0]       s1_rect_reg [0:3];
    logic signed [31:0]        s1_rot_reg;
    logic [2:0]                s1_kind_reg;
    logic                      s1_slope_reg;
    logic [1:0]                s1_sup_reg;
    logic signed [48:0]        s1_qprod_reg;
    logic signed [48:0]        qprod_next;
    logic signed [20:0]        rot_t;

    assign rot_t      = $signed(s_tdata[4*W+31:4*W+11]);
    assign qprod_next = rot_t * RECIP45;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s1_rect_reg[i] <= $signed(s_tdata[i*W +: W]);
            end
            s1_rot_reg   <= $signed(s_tdata[4*W +: 32]);
            s1_kind_reg  <= s_tuser[2:0];
            s1_slope_reg <= s_tuser[3];
            s1_sup_reg   <= s_tuser[5:4];
            s1_qprod_reg <= qprod_next;
        end
    end

    // ---------------- stage 2: remainder and magnitude test
    logic                s2_valid_reg;
    logic signed [W-1:0] s2_rect_reg [0:3];
    logic [16:0]         s2_n_reg;
    logic                s2_big_reg;
    logic [2:0]          s2_kind_reg;
    logic                s2_slope_reg;
    logic [1:0]          s2_sup_reg;
    logic [16:0]         n_next;
    logic                big_next;

    always_comb
    begin
        logic signed [33:0] q_ext;
        logic signed [33:0] rot_ext;
        logic signed [33:0] r;
        q_ext    = 34'($signed(s1_qprod_reg[48:32]));
        rot_ext  = 34'(s1_rot_reg);
        r        = rot_ext - q_ext * 34'sd92160;
        // the rounded-up reciprocal leaves the quotient one too low on negative multiples of 45
        if (r >= 34'sd92160)
        begin
            r = r - 34'sd92160;
        end
        n_next   = r[16:0];
        if (rot_ext < 0)
        begin
            big_next = (-rot_ext) > $signed({26'd0, tol_reg});
        end
        else
        begin
            big_next = rot_ext > $signed({26'd0, tol_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_rect_reg  <= s1_rect_reg;
            s2_n_reg     <= n_next;
            s2_big_reg   <= big_next;
            s2_kind_reg  <= s1_kind_reg;
            s2_slope_reg <= s1_slope_reg;
            s2_sup_reg   <= s1_sup_reg;
        end
    end

    // ---------------- stage 3: fold to [-90, 90], classify
    logic [SIDE_W-1:0] side_reg [0:N];
    logic              vline_reg [0:N];
    cordic_t           cs [0:N];
    cordic_t           cs0_reg;
    logic [SIDE_W-1:0] side_next;
    cordic_t           cs0_next;

    always_comb
    begin
        logic [16:0]        d;
        logic               near;
        logic signed [17:0] a;
        logic               flip;
        logic [2:0]         shape;
        logic               verif;
        logic               tri_v;
        logic               rot_v;
        if (s2_n_reg >= DEG270)
        begin
            d = s2_n_reg - DEG270;
        end
        else if (s2_n_reg >= DEG180)
        begin
            d = s2_n_reg - DEG180;
        end
        else if (s2_n_reg >= DEG90)
        begin
            d = s2_n_reg - DEG90;
        end
        else
        begin
            d = s2_n_reg;
        end
        near = (d < {9'd0, tol_reg}) || ((DEG90 - d) < {9'd0, tol_reg});

        flip = 1'b0;
        if (s2_n_reg >= DEG270)
        begin
            a = $signed({1'b0, s2_n_reg}) - $signed({1'b0, DEG360});
        end
        else if (s2_n_reg > DEG90)
        begin
            a    = $signed({1'b0, s2_n_reg}) - $signed({1'b0, DEG180});
            flip = 1'b1;
        end
        else
        begin
            a = $signed({1'b0, s2_n_reg});
        end

        tri_v = 1'b0;
        if (s2_kind_reg == KIND_SOLID)
        begin
            verif = 1'b0;
            if (s2_slope_reg)
            begin
                shape = SHAPE_TRIANGLE;
                tri_v = 1'b1;
                rot_v = 1'b1;
            end
            else if (near)
            begin
                shape = SHAPE_AXIS;
                rot_v = 1'b0;
            end
            else
            begin
                shape = SHAPE_ROTATED;
                rot_v = s2_big_reg;
            end
        end
        else if (s2_kind_reg == KIND_HAZARD)
        begin
            shape = SHAPE_HAZARD;
            verif = 1'b0;
            rot_v = s2_big_reg;
        end
        else
        begin
            shape = SHAPE_REF;
            verif = 1'b1;
            rot_v = s2_big_reg;
        end
        if (s2_sup_reg == SUPPORT_NONE)
        begin
            verif = 1'b1;
        end

        side_next = {flip, rot_v, tri_v, verif, shape,
                     s2_rect_reg[3], s2_rect_reg[2], s2_rect_reg[1], s2_rect_reg[0]};
        cs0_next.x = CORDIC_GAIN;
        cs0_next.y = '0;
        cs0_next.z = ZW'(a) <<< 8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N; i++)
            begin
                vline_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vline_reg[0] <= s2_valid_reg;
            for (int i = 1; i <= N; i++)
            begin
                vline_reg[i] <= vline_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            cs0_reg     <= cs0_next;
            for (int i = 1; i <= N; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign cs[0] = cs0_reg;

    // ---------------- CORDIC cell chain
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        rpvg_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .clk  (clk),
            .en   (adv),
            .din  (cs[g]),
            .dout (cs[g+1])
        );
    end

    // ---------------- stage 4: corners, centre, offsets
    logic                     s4_valid_reg;
    logic signed [OW-1:0]     s4_corner_reg [0:3];   // left, right, bottom, top
    logic signed [OW-1:0]     s4_off_reg [0:3];
    logic signed [OW-1:0]     s4_cx_reg;
    logic signed [OW-1:0]     s4_cy_reg;
    logic signed [CW-1:0]     s4_c_reg;
    logic signed [CW-1:0]     s4_s_reg;
    logic [5:0]               s4_meta_reg;            // shape, verif, tri, rotate
    logic signed [OW-1:0]     corner_next [0:3];
    logic signed [OW-1:0]     off_next [0:3];
    logic signed [OW-1:0]     cx_next;
    logic signed [OW-1:0]     cy_next;

    always_comb
    begin
        logic [SIDE_W-1:0]   sd;
        logic signed [OW-1:0] x1;
        logic signed [OW-1:0] x2;
        logic signed [OW-1:0] y1;
        logic signed [OW-1:0] y2;
        logic signed [OW:0]   sx;
        logic signed [OW:0]   sy;
        sd = side_reg[N];
        x1 = OW'($signed(sd[W-1:0]));
        y1 = OW'($signed(sd[2*W-1:W]));
        x2 = x1 + OW'($signed(sd[3*W-1:2*W]));
        y2 = y1 + OW'($signed(sd[4*W-1:3*W]));
        corner_next[0] = (x1 < x2) ? x1 : x2;
        corner_next[1] = (x1 < x2) ? x2 : x1;
        corner_next[2] = (y1 < y2) ? y1 : y2;
        corner_next[3] = (y1 < y2) ? y2 : y1;
        sx = (OW+1)'(corner_next[0]) + (OW+1)'(corner_next[1]);
        sy = (OW+1)'(corner_next[2]) + (OW+1)'(corner_next[3]);
        cx_next = OW'(sx >>> 1);
        cy_next = OW'(sy >>> 1);
        off_next[0] = corner_next[0] - cx_next;
        off_next[1] = corner_next[1] - cx_next;
        off_next[2] = corner_next[2] - cy_next;
        off_next[3] = corner_next[3] - cy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= vline_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_corner_reg <= corner_next;
            s4_off_reg    <= off_next;
            s4_cx_reg     <= cx_next;
            s4_cy_reg     <= cy_next;
            s4_c_reg      <= side_reg[N][4*W+6] ? -cs[N].x : cs[N].x;
            s4_s_reg      <= side_reg[N][4*W+6] ? -cs[N].y : cs[N].y;
            s4_meta_reg   <= side_reg[N][4*W+5:4*W];
        end
    end

    // ---------------- stage 5: partial products
    // products 0..3: offset L, R, B, T times cosine; 4..7: the same times sine
    logic                        s5_valid_reg;
    logic signed [OW-1:0]        s5_corner_reg [0:3];
    logic signed [OW-1:0]        s5_cx_reg;
    logic signed [OW-1:0]        s5_cy_reg;
    logic [5:0]                  s5_meta_reg;
    logic signed [48:0]          s5_lo_reg [0:7];
    logic signed [OW+15:0]       s5_hi_reg [0:7];
    logic signed [48:0]          lo_next [0:7];
    logic signed [OW+15:0]       hi_next [0:7];

    always_comb
    begin
        logic signed [16:0]    a_lo;
        logic signed [OW-17:0] a_hi;
        logic signed [CW-1:0]  b;
        for (int j = 0; j < 8; j++)
        begin
            a_lo       = $signed({1'b0, s4_off_reg[j % 4][15:0]});
            a_hi       = $signed(s4_off_reg[j % 4][OW-1:16]);
            b          = (j < 4) ? s4_c_reg : s4_s_reg;
            lo_next[j] = a_lo * b;
            hi_next[j] = a_hi * b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_corner_reg <= s4_corner_reg;
            s5_cx_reg     <= s4_cx_reg;
            s5_cy_reg     <= s4_cy_reg;
            s5_meta_reg   <= s4_meta_reg;
            s5_lo_reg     <= lo_next;
            s5_hi_reg     <= hi_next;
        end
    end

    // ---------------- stage 6: full products
    logic                 s6_valid_reg;
    logic signed [OW-1:0] s6_corner_reg [0:3];
    logic signed [OW-1:0] s6_cx_reg;
    logic signed [OW-1:0] s6_cy_reg;
    logic [5:0]           s6_meta_reg;
    logic signed [PW-1:0] s6_prod_reg [0:7];
    logic signed [PW-1:0] prod_next [0:7];

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            prod_next[j] = (PW'(s5_hi_reg[j]) <<< 16) + PW'(s5_lo_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_corner_reg <= s5_corner_reg;
            s6_cx_reg     <= s5_cx_reg;
            s6_cy_reg     <= s5_cy_reg;
            s6_meta_reg   <= s5_meta_reg;
            s6_prod_reg   <= prod_next;
        end
    end

    // ---------------- stage 7: round, recentre, saturate
    logic                s7_valid_reg;
    logic signed [W-1:0] s7_vx_reg [0:3];
    logic signed [W-1:0] s7_vy_reg [0:3];
    logic [5:0]          s7_meta_reg;
    logic signed [W-1:0] vx_next [0:3];
    logic signed [W-1:0] vy_next [0:3];

    always_comb
    begin
        int                   xi;
        int                   yi;
        logic signed [SW-1:0] ex;
        logic signed [SW-1:0] ey;
        for (int k = 0; k < 4; k++)
        begin
            xi = (k == 0 || k == 3) ? 0 : 1;
            yi = (k < 2) ? 0 : 1;
            if (s6_meta_reg[5])
            begin
                ex = SW'(s6_prod_reg[xi]) - SW'(s6_prod_reg[6+yi]) + ROUND;
                ey = SW'(s6_prod_reg[4+xi]) + SW'(s6_prod_reg[2+yi]) + ROUND;
                ex = (ex >>> 30) + SW'(s6_cx_reg);
                ey = (ey >>> 30) + SW'(s6_cy_reg);
            end
            else
            begin
                ex = SW'(s6_corner_reg[xi]);
                ey = SW'(s6_corner_reg[2+yi]);
            end
            if (ex > SAT_HI)
            begin
                ex = SAT_HI;
            end
            else if (ex < SAT_LO)
            begin
                ex = SAT_LO;
            end
            if (ey > SAT_HI)
            begin
                ey = SAT_HI;
            end
            else if (ey < SAT_LO)
            begin
                ey = SAT_LO;
            end
            vx_next[k] = ex[W-1:0];
            vy_next[k] = ey[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_vx_reg   <= vx_next;
            s7_vy_reg   <= vy_next;
            s7_meta_reg <= s6_meta_reg;
        end
    end

    // ---------------- output register: one vertex per transaction
    logic                em_valid_reg;
    logic [1:0]          cnt_reg;
    logic signed [W-1:0] em_vx_reg [0:3];
    logic signed [W-1:0] em_vy_reg [0:3];
    logic [2:0]          em_shape_reg;
    logic                em_verif_reg;
    logic                em_tri_reg;
    logic                em_last;

    assign em_last = em_tri_reg ? (cnt_reg == 2'd2) : (cnt_reg == 2'd3);
    assign load    = s7_valid_reg && (!em_valid_reg || (m_tready && em_last));
    assign adv     = !s7_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else if (load)
        begin
            em_valid_reg <= 1'b1;
            cnt_reg      <= 2'd0;
        end
        else if (em_valid_reg && m_tready)
        begin
            if (em_last)
            begin
                em_valid_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            em_vx_reg    <= s7_vx_reg;
            em_vy_reg    <= s7_vy_reg;
            em_shape_reg <= s7_meta_reg[2:0];
            em_verif_reg <= s7_meta_reg[3];
            em_tri_reg   <= s7_meta_reg[4];
        end
    end

    assign m_tvalid = em_valid_reg;
    assign m_tdata  = OUT_W'({cnt_reg, em_vy_reg[cnt_reg], em_vx_reg[cnt_reg]});
    assign m_tuser  = {em_verif_reg, em_shape_reg};
    assign m_tlast  = em_last;

endmodule
